// File: src/ubvt_pkg.sv
// ubvt_pkg: sizes and helper types for the unique bit vector table.
// No dependencies; every other file in src imports it.
package ubvt_pkg;

	localparam int TABLE_DEPTH       = 256;
	localparam int SAMPLE_INDEX_BITS = 16;
	localparam int MAX_VECTOR_BITS   = 64;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int VBW_W = 7;

	localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
	localparam logic [VBW_W-1:0] VBITS_RST  = VBW_W'(MAX_VECTOR_BITS);

	typedef logic [MAX_VECTOR_BITS-1:0]   vec_t;
	typedef logic [SAMPLE_INDEX_BITS-1:0] smp_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	// one table entry as held in the memory
	typedef struct packed {
		vec_t vec;
		smp_t first;
	} entry_t;

	// comparison mask for a given width setting; zero compares nothing
	function automatic vec_t compare_mask(input logic [VBW_W-1:0] bits);
		vec_t m;
		if (bits >= VBITS_RST) begin
			m = '1;
		end else begin
			m = (vec_t'(1) << bits) - vec_t'(1);
		end
		return m;
	endfunction

endpackage

// File: src/ubvt_if.sv
// ubvt_in_if / ubvt_out_if: valid/ready channels for input and result words.
// Depends on ubvt_pkg.
interface ubvt_in_if import ubvt_pkg::*; ();
	logic valid;
	logic ready;
	vec_t model_bits;
	logic last_sample;

	modport source (output valid, output model_bits, output last_sample, input ready);
	modport sink   (input valid, input model_bits, input last_sample, output ready);
endinterface

interface ubvt_out_if import ubvt_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       is_new;
	logic [7:0] entry_index;
	smp_t       first_sample_index;
	logic [8:0] distinct_count;
	logic       table_full;

	modport source (output valid, output is_new, output entry_index,
		output first_sample_index, output distinct_count, output table_full,
		input ready);
	modport sink   (input valid, input is_new, input entry_index,
		input first_sample_index, input distinct_count, input table_full,
		output ready);
endinterface

// File: src/unique_bit_vector_table.sv
// unique_bit_vector_table: duplicate elimination table over a vector stream.
// Depends on ubvt_pkg and the channel interfaces in ubvt_if.sv.

// One input word is taken at a time. The word is checked against the stored
// distinct vectors one entry per cycle through a single-port-read 256-entry
// table memory with a registered read port. A match ends the scan early; an
// empty table skips the scan. The result goes into the output register once
// that register is free, and only then can the next input word be taken.
// Matches compare only the low vector_bits bits (0 compares nothing, 64 and
// above compare all 64). A new vector is stored with the sample number where
// it first appeared; a new vector that meets a full table is reported with
// table_full set and is not stored. A word with last_sample set ends the set:
// after its result the distinct count and the sample counter restart from
// zero. The table memory needs no clearing pass; only entries below the
// distinct count are ever compared. The result sits in an output register,
// so the next word is taken while a result waits.
module unique_bit_vector_table import ubvt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [VBW_W-1:0] cfg_wdata,
	ubvt_in_if.sink          samples,
	ubvt_out_if.source       results
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [VBW_W-1:0] vbits_q;
	cnt_t             count_q;
	smp_t             sample_q;

	// current word
	vec_t vec_q;
	vec_t mask_q;
	logic last_q;

	// scan control: iss_q is the next entry to read, chk_* the entry in flight
	cnt_t iss_q;
	logic chk_vld_s1;
	idx_t chk_idx_s1;
	logic found_q;
	idx_t hit_idx_q;
	smp_t hit_first_q;

	// table memory
	entry_t mem [TABLE_DEPTH];
	entry_t rd_data_s1;
	idx_t   rd_addr;
	logic   wr_en;

	// output register
	logic       out_vld_q;
	logic       is_new_q;
	logic [7:0] entry_q;
	smp_t       first_q;
	logic [8:0] dcount_q;
	logic       full_q;

	logic accept;
	logic hit;
	logic issue;
	logic out_free;
	logic tbl_full;

	assign accept   = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);
	assign hit      = chk_vld_s1 && (((rd_data_s1.vec ^ vec_q) & mask_q) == '0);
	assign issue    = (state_q == ST_SCAN) && !hit && (iss_q < count_q);
	assign rd_addr  = iss_q[IDX_W-1:0];
	assign out_free = !out_vld_q || results.ready;
	assign tbl_full = (count_q == DEPTH_CNT);
	// store only in the finishing cycle; the next scan starts later, so a read
	// that feeds a compare never meets a write to the same entry
	assign wr_en    = (state_q == ST_FIN) && out_free && !found_q && !tbl_full;

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IDX_W-1:0]] <= '{vec: vec_q, first: sample_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbits_q <= VBITS_RST;
		end else if (cfg_we) begin
			vbits_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vec_q  <= samples.model_bits;
			last_q <= samples.last_sample;
			mask_q <= compare_mask(vbits_q);
		end
		if (state_q == ST_SCAN && hit) begin
			hit_idx_q   <= chk_idx_s1;
			hit_first_q <= rd_data_s1.first;
		end
		if (issue) begin
			chk_idx_s1 <= rd_addr;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			sample_q   <= '0;
			iss_q      <= '0;
			chk_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						iss_q      <= '0;
						chk_vld_s1 <= 1'b0;
						found_q    <= 1'b0;
						state_q    <= (count_q == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_vld_s1 <= issue;
					if (issue) begin
						iss_q <= iss_q + cnt_t'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
						state_q <= ST_FIN;
					end else if (!issue && !chk_vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (wr_en && !last_q) begin
							count_q <= count_q + cnt_t'(1);
						end
						if (last_q) begin
							count_q  <= '0;
							sample_q <= '0;
						end else begin
							sample_q <= sample_q + smp_t'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			is_new_q <= !found_q;
			full_q   <= !found_q && tbl_full;
			if (found_q) begin
				entry_q  <= 8'(hit_idx_q);
				first_q  <= hit_first_q;
				dcount_q <= 9'(count_q);
			end else if (tbl_full) begin
				entry_q  <= '0;
				first_q  <= sample_q;
				dcount_q <= 9'(count_q);
			end else begin
				entry_q  <= 8'(count_q);
				first_q  <= sample_q;
				dcount_q <= 9'(count_q + cnt_t'(1));
			end
		end
	end

	assign results.valid              = out_vld_q;
	assign results.is_new             = is_new_q;
	assign results.entry_index        = entry_q;
	assign results.first_sample_index = first_q;
	assign results.distinct_count     = dcount_q;
	assign results.table_full         = full_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("distinct count beyond table depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (iss_q <= count_q))
		else $error("scan pointer past stored entries");

	a_hit_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !is_new_q) |-> (!full_q && (9'(entry_q) < dcount_q)))
		else $error("matched entry outside stored range");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!tbl_full && !found_q))
		else $error("store into full table or on a match");

endmodule

// File: tb/sv/ubvt_monitor.sv
// ubvt_monitor: watches the sample and result channels of the unique bit
// vector table, predicts every result word and compares. Depends on ubvt_pkg
// and the channel interfaces in ubvt_if.sv.
module ubvt_monitor import ubvt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [VBW_W-1:0] cfg_wdata,
	ubvt_in_if               samples,
	ubvt_out_if              results,
	output int unsigned      mismatches,
	output int unsigned      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       is_new;
		logic [7:0] entry_index;
		smp_t       first_sample_index;
		logic [8:0] distinct_count;
		logic       table_full;
	} verdict_t;

	// shadow copy of the block's state
	vec_t             seen_vec   [TABLE_DEPTH];
	smp_t             seen_first [TABLE_DEPTH];
	int unsigned      n_distinct;
	smp_t             sample_no;
	logic [VBW_W-1:0] width_bits;

	verdict_t awaited [$];

	// looks one vector up, stores it if new, advances the sample count (or restarts the set on its last sample)
	function automatic verdict_t record_sample(input vec_t v, input logic fin);
		verdict_t    r;
		vec_t        m;
		bit          hit;
		int unsigned e;
		if (int'(width_bits) >= MAX_VECTOR_BITS) begin
			m = '1;
		end else begin
			m = ~(vec_t'('1) << width_bits);
		end
		r = '0;
		r.is_new = 1'b1;
		r.first_sample_index = sample_no;
		hit = 1'b0;
		for (e = 0; e < n_distinct && !hit; e++) begin
			if (((seen_vec[e] ^ v) & m) == '0) begin
				hit = 1'b1;
				r.is_new = 1'b0;
				r.entry_index = 8'(e);
				r.first_sample_index = seen_first[e];
			end
		end
		if (!hit) begin
			if (n_distinct < TABLE_DEPTH) begin
				seen_vec[n_distinct] = v;
				seen_first[n_distinct] = sample_no;
				r.entry_index = 8'(n_distinct);
				n_distinct++;
			end else begin
				r.table_full = 1'b1;
			end
		end
		r.distinct_count = 9'(n_distinct);
		if (fin) begin
			n_distinct = 0;
			sample_no = '0;
		end else begin
			sample_no = sample_no + 1'b1;
		end
		return r;
	endfunction

	function automatic string show(input verdict_t r);
		return $sformatf("new=%0b entry=%0d first=%0d count=%0d full=%0b",
			r.is_new, r.entry_index, r.first_sample_index, r.distinct_count,
			r.table_full);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			width_bits = VBITS_RST;
			n_distinct = 0;
			sample_no = '0;
			awaited.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				width_bits = cfg_wdata;
			end
			if (samples.valid && samples.ready) begin
				awaited.push_back(record_sample(samples.model_bits, samples.last_sample));
			end
			if (results.valid && results.ready) begin
				got = {results.is_new, results.entry_index, results.first_sample_index,
					results.distinct_count, results.table_full};
				if (awaited.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result word with none awaited: %s", $realtime, show(got));
					end
				end else begin
					want = awaited.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result mismatch\n  expected %s\n  actual   %s",
								$realtime, show(want), show(got));
						end
					end
				end
			end
			outstanding = awaited.size();
		end
	end

endmodule

// File: tb/sv/unique_bit_vector_table_tb.sv
// unique_bit_vector_table_tb: drives sample words into the unique bit vector
// table, paces the result side and gives the verdict. Depends on ubvt_pkg,
// ubvt_if.sv, the block itself and ubvt_monitor.
module unique_bit_vector_table_tb import ubvt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Slowest legal run: about 650 words, each scanning a full table with
	// stalls; the limit leaves ample room.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	// Long enough for the block to fill its output register and one word in
	// flight, so samples.ready has to drop while the sender keeps offering.
	localparam int unsigned HOLD_CYCLES = 600;
	// Slowest single word: a full table scan plus the memory read latency.
	localparam int unsigned SCAN_CYCLES = 260;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [VBW_W-1:0] cfg_wdata;

	ubvt_in_if  samples ();
	ubvt_out_if results ();

	int unsigned mismatches;
	int unsigned outstanding;

	// idle percentages for each side, set per phase by the stimulus
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	// a long result hold-off is requested by bumping hold_ask
	int unsigned hold_ask;
	int unsigned hold_done;
	int unsigned cycles;

	unique_bit_vector_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.results   (results)
	);

	ubvt_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.samples     (samples),
		.results     (results),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one sample word, after a random gap, and hold it until taken.
	// Returns at the edge that accepted it, with valid still high, so the
	// next call can keep valid up without a dip.
	task automatic push_word(input vec_t v, input logic fin);
		while ($urandom_range(99) < tx_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.model_bits <= v;
		samples.last_sample <= fin;
		do @(posedge clk); while (!(samples.valid && samples.ready));
	endtask

	// Stop offering and wait until every predicted result word came back.
	// An idle block has nothing in flight, since each word gives one result.
	task automatic wait_idle();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// vector_bits write; only called right after wait_idle
	task automatic write_width(input logic [VBW_W-1:0] w);
		cfg_wdata <= w;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side pacing. Runs on its own so that a long hold-off keeps
	// counting while the stimulus goes on offering words.
	initial begin : result_pacing
		int unsigned held;
		forever begin
			if (hold_ask != hold_done) begin
				hold_done = hold_ask;
				results.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
			end else begin
				results.ready <= ($urandom_range(99) >= rx_idle_pct);
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		vec_t             v;
		vec_t             kept;
		vec_t             pool [12];
		int unsigned      pool_n;
		int unsigned      set_left;
		int unsigned      pick;
		int unsigned      seg;
		int               i;
		logic [VBW_W-1:0] w;

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_ask = 0;
		hold_done = 0;
		samples.valid <= 1'b0;
		samples.model_bits <= '0;
		samples.last_sample <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, full 64-bit compare from reset ---
		// all-zero and all-one words, their repeats, single high/low bits,
		// alternating patterns; a repeat closes the set
		push_word('0, 1'b0);
		push_word('1, 1'b0);
		push_word('0, 1'b0);
		push_word('1, 1'b0);
		push_word(64'h8000_0000_0000_0000, 1'b0);
		push_word(64'h0000_0000_0000_0001, 1'b0);
		push_word(64'h5555_5555_5555_5555, 1'b0);
		push_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		push_word(64'h0000_0000_0000_0001, 1'b1);
		// fresh set starts at entry 0, sample 0
		push_word('0, 1'b0);
		// width drops to one bit mid-set: both sides get the new mask
		wait_idle();
		write_width(7'd1);
		push_word(64'h0000_0000_0000_0002, 1'b0);
		push_word('1, 1'b0);
		// zero width compares nothing: any word hits entry 0
		wait_idle();
		write_width(7'd0);
		push_word({$urandom, $urandom}, 1'b0);
		// above 64 behaves as 64
		wait_idle();
		write_width(7'd127);
		push_word('1, 1'b0);
		push_word(64'h0000_0000_0000_0002, 1'b1);
		wait_idle();
		write_width(7'd64);

		// --- full table: 256 distinct words, then new ones that find no room ---
		for (i = 0; i < TABLE_DEPTH; i++) begin
			v = {$urandom, $urandom};
			v[7:0] = i[7:0];
			if (i == 7) kept = v;
			push_word(v, 1'b0);
		end
		repeat (3) push_word({$urandom, $urandom}, 1'b0);
		push_word(kept, 1'b0);
		// narrow the mask on a full table: low byte picks the old entry
		wait_idle();
		write_width(7'd8);
		v = {$urandom, $urandom};
		v[7:0] = 8'h2A;
		push_word(v, 1'b1);

		// --- random sets: pools of repeating vectors with some noise ---
		// Six segments, each with its own width; sets run across segment
		// boundaries, so width changes also land mid-set.
		set_left = 0;
		pool_n = 1;
		for (seg = 0; seg < 6; seg++) begin
			wait_idle();
			case (seg)
				0: w = 7'd64;
				1: w = 7'd1;
				2: w = 7'($urandom_range(2, 63));
				3: w = 7'($urandom_range(65, 127));
				default: w = 7'($urandom_range(1, 64));
			endcase
			write_width(w);
			case (seg / 2)
				0: begin
					tx_idle_pct = 31;
					rx_idle_pct = 45;
				end
				1: begin
					tx_idle_pct = 45;
					rx_idle_pct = 31;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			// backpressure burst: result side stops while words keep coming
			if (seg == 4) hold_ask++;
			repeat (62) begin
				if (set_left == 0) begin
					set_left = $urandom_range(1, 40);
					pool_n = $urandom_range(1, 12);
					for (i = 0; i < int'(pool_n); i++) pool[i] = {$urandom, $urandom};
				end
				pick = $urandom_range(99);
				if (pick < 85) begin
					v = pool[$urandom_range(pool_n - 1)];
				end else if (pick < 95) begin
					v = {$urandom, $urandom};
				end else begin
					// near miss: one flipped bit, may fall outside the mask
					v = pool[$urandom_range(pool_n - 1)] ^ (vec_t'(1) << $urandom_range(63));
				end
				set_left--;
				push_word(v, set_left == 0);
			end
		end

		// --- wind down: drain, allow one full scan, then the verdict ---
		wait_idle();
		repeat (SCAN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/ubvt_pkg.sv
src/ubvt_if.sv
src/unique_bit_vector_table.sv
tb/sv/ubvt_monitor.sv
tb/sv/unique_bit_vector_table_tb.sv
